// ===== rtl/core/jflt_pkg.sv =====
// Shared constants, tanh table and saturation helper for the joint friction block.
`default_nettype none
package jflt_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_INV_VEL_SCALE = 2'd0;
  localparam logic [1:0] CFG_LIMIT_STIFF   = 2'd1;
  localparam logic [1:0] CFG_LIMIT_DAMP    = 2'd2;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int TanhPoints = 257;

  typedef logic [16:0] tanh_rom_t [0:TanhPoints-1];

  // Build tanh(i/64) in unsigned Q1.16 from a Q24 exponential recurrence.
  // The rounded quotient comes from a shift-subtract loop at elaboration.
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    longint unsigned a;
    longint unsigned num;
    longint unsigned den;
    longint unsigned rem;
    longint unsigned quo;
    a = 64'd16777216;
    for (int i = 0; i < TanhPoints; i++) begin
      den = a + 64'd16777216;
      num = (a - 64'd16777216) * 64'd65536 + (den >> 1);
      rem = 64'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem = rem - den;
          quo = {quo[62:0], 1'b1};
        end else begin
          quo = {quo[62:0], 1'b0};
        end
      end
      rom[i] = quo[16:0];
      a = a + ((a * 64'd532566) >> 24);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  // Clamp a wide signed value to 32 bits.
  function automatic logic [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/joint_friction_limit_torque.sv =====
// Top level of the per-joint viscous, Coulomb and joint-stop torque evaluator.
`default_nettype none
// Load transactions (opcode 0) store one joint's damping, friction and limits; evaluate
// transactions (opcode 1) return viscous, tanh-smoothed Coulomb, joint-stop and total
// torque in signed Q16.16. One transaction is accepted per clock unless a result stalls;
// the accepting edge performs the parameter RAM read, four multiply and table stages
// follow, and the output register presents an evaluate result. A stalled result
// holds every stage and the input. A load takes effect for an evaluate accepted in the
// very next cycle. Rows never loaded, or loaded with upper below lower, report status 1.
module joint_friction_limit_torque #(
  parameter int JOINTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [2:0]  in_joint,
  input  wire logic [31:0] in_position,
  input  wire logic [31:0] in_velocity,
  input  wire logic [30:0] in_damping_in,
  input  wire logic [30:0] in_friction_in,
  input  wire logic [31:0] in_lower_in,
  input  wire logic [31:0] in_upper_in,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_joint_out,
  output logic             out_status,
  output logic [31:0]      out_viscous_torque,
  output logic [31:0]      out_friction_torque,
  output logic [31:0]      out_limit_torque,
  output logic [31:0]      out_total_torque
);
  import jflt_pkg::*;

  localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Configuration registers
  logic [30:0] scale_r, stiff_r, kd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 31'd65536;
      stiff_r <= 31'd0;
      kd_r    <= 31'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INV_VEL_SCALE: scale_r <= cfg_data[30:0];
        CFG_LIMIT_STIFF:   stiff_r <= cfg_data[30:0];
        CFG_LIMIT_DAMP:    kd_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: move every stage when the output slot frees
  logic adv;
  logic in_fire, load_fire, eval_fire;
  logic [AW+2:0] jext;
  logic [AW-1:0] addr;
  logic          jok;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign in_fire   = in_valid && in_ready;
  assign jext      = {AW'(0), in_joint};
  assign addr      = jext[AW-1:0];
  assign jok       = jext < (AW+3)'(JOINTS);
  assign load_fire = in_fire && (in_opcode == OP_LOAD) && jok;
  assign eval_fire = in_fire && (in_opcode == OP_EVAL);

  // Row valid flags
  logic [JOINTS-1:0] row_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (load_fire) begin
      row_valid_r[addr] <= ($signed(in_upper_in) >= $signed(in_lower_in));
    end
  end

  // Parameter memories
  logic [61:0] fric_rd;
  logic [63:0] lim_rd;

  jflt_ram #(.WIDTH(62), .DEPTH(JOINTS)) u_fric_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (addr),
    .wdata ({in_friction_in, in_damping_in}),
    .re    (eval_fire),
    .raddr (addr),
    .rdata (fric_rd)
  );

  jflt_ram #(.WIDTH(64), .DEPTH(JOINTS)) u_lim_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (addr),
    .wdata ({in_upper_in, in_lower_in}),
    .re    (eval_fire),
    .raddr (addr),
    .rdata (lim_rd)
  );

  // Stage 1: item registers alongside RAM data
  logic        v1_r, ok1_r;
  logic [2:0]  j1_r;
  logic [31:0] pos1_r, vel1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= eval_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r  <= jok && row_valid_r[addr];
      j1_r   <= in_joint;
      pos1_r <= in_position;
      vel1_r <= in_velocity;
    end
  end

  logic signed [31:0] vel_s, pos_s, lo_s, up_s;
  logic signed [32:0] nvel;
  logic signed [63:0] prodx;
  logic signed [64:0] pvisc;
  logic               above, below;
  logic signed [32:0] diff_nxt, dvel_nxt;

  assign vel_s = $signed(vel1_r);
  assign pos_s = $signed(pos1_r);
  assign lo_s  = $signed(lim_rd[31:0]);
  assign up_s  = $signed(lim_rd[63:32]);
  assign nvel  = -$signed({vel1_r[31], vel1_r});
  assign prodx = $signed({1'b0, scale_r}) * vel_s;
  assign pvisc = $signed({1'b0, fric_rd[30:0]}) * nvel;
  assign above = pos_s > up_s;
  assign below = pos_s < lo_s;

  // Pick stop penetration and inward velocity
  always_comb begin
    diff_nxt = '0;
    dvel_nxt = '0;
    if (above) begin
      diff_nxt = 33'(pos_s) - 33'(up_s);
      dvel_nxt = (vel_s > 0) ? 33'(vel_s) : 33'sd0;
    end else if (below) begin
      diff_nxt = 33'(lo_s) - 33'(pos_s);
      dvel_nxt = (vel_s < 0) ? nvel : 33'sd0;
    end
  end

  // Stage 2
  logic               v2_r, ok2_r, above2_r, limen2_r;
  logic [2:0]         j2_r;
  logic signed [47:0] x2_r;
  logic [31:0]        visc2_r;
  logic [30:0]        c2_r;
  logic signed [32:0] diff2_r, dvel2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok2_r    <= ok1_r;
      j2_r     <= j1_r;
      x2_r     <= prodx[63:16];
      visc2_r  <= sat32(66'($signed(pvisc[64:16])));
      c2_r     <= fric_rd[61:31];
      above2_r <= above;
      limen2_r <= (stiff_r != 31'd0) && (above || below);
      diff2_r  <= diff_nxt;
      dvel2_r  <= dvel_nxt;
    end
  end

  logic [47:0]        mag;
  logic [8:0]         idx;
  logic signed [64:0] ks, kds;

  assign mag = x2_r[47] ? 48'(-x2_r) : 48'(x2_r);
  assign idx = {1'b0, mag[17:10]};
  assign ks  = $signed({1'b0, stiff_r}) * diff2_r;
  assign kds = $signed({1'b0, kd_r}) * dvel2_r;

  // Stage 3
  logic               v3_r, ok3_r, above3_r, limen3_r, neg3_r, sat3_r;
  logic [2:0]         j3_r;
  logic [31:0]        visc3_r;
  logic [30:0]        c3_r;
  logic [16:0]        t0_r, t1_r;
  logic [9:0]         f3_r;
  logic signed [48:0] sp3_r, dp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok3_r    <= ok2_r;
      j3_r     <= j2_r;
      visc3_r  <= visc2_r;
      c3_r     <= c2_r;
      above3_r <= above2_r;
      limen3_r <= limen2_r;
      neg3_r   <= x2_r[47];
      sat3_r   <= |mag[47:18];
      t0_r     <= TANH_ROM[idx];
      t1_r     <= TANH_ROM[idx + 9'd1];
      f3_r     <= mag[9:0];
      sp3_r    <= ks[64:16];
      dp3_r    <= kds[64:16];
    end
  end

  logic signed [17:0] tdel;
  logic signed [28:0] tprod;
  logic signed [17:0] tmag, tanh_nxt;
  logic signed [49:0] limsum;
  logic [31:0]        lim_nxt;

  assign tdel   = $signed({1'b0, t1_r}) - $signed({1'b0, t0_r});
  assign tprod  = tdel * $signed({1'b0, f3_r});
  assign tmag   = sat3_r ? 18'sd65536 : ($signed({1'b0, t0_r}) + 18'(tprod >>> 10));
  assign tanh_nxt = neg3_r ? -tmag : tmag;
  assign limsum = 50'(sp3_r) + 50'(dp3_r);

  // Apply stop direction
  always_comb begin
    lim_nxt = '0;
    if (limen3_r) begin
      lim_nxt = above3_r ? sat32(66'(-limsum)) : sat32(66'(limsum));
    end
  end

  // Stage 4
  logic               v4_r, ok4_r;
  logic [2:0]         j4_r;
  logic [31:0]        visc4_r, lim4_r;
  logic [30:0]        c4_r;
  logic signed [17:0] tanh4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok4_r   <= ok3_r;
      j4_r    <= j3_r;
      visc4_r <= visc3_r;
      lim4_r  <= lim_nxt;
      c4_r    <= c3_r;
      tanh4_r <= tanh_nxt;
    end
  end

  logic signed [18:0] ntanh;
  logic signed [50:0] pfric;

  assign ntanh = -19'(tanh4_r);
  assign pfric = $signed({1'b0, c4_r}) * ntanh;

  // Stage 5
  logic        v5_r, ok5_r;
  logic [2:0]  j5_r;
  logic [31:0] visc5_r, fric5_r, lim5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok5_r   <= ok4_r;
      j5_r    <= j4_r;
      visc5_r <= visc4_r;
      fric5_r <= sat32(66'($signed(pfric[50:16])));
      lim5_r  <= lim4_r;
    end
  end

  logic signed [33:0] tot;

  assign tot = 34'($signed(visc5_r)) + 34'($signed(fric5_r)) + 34'($signed(lim5_r));

  // Output register; invalid rows report zero torques
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_joint_out       <= j5_r;
      out_status          <= !ok5_r;
      out_viscous_torque  <= ok5_r ? visc5_r : 32'd0;
      out_friction_torque <= ok5_r ? fric5_r : 32'd0;
      out_limit_torque    <= ok5_r ? lim5_r : 32'd0;
      out_total_torque    <= ok5_r ? sat32(66'(tot)) : 32'd0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/core/jflt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jflt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/jflt_checker.sv =====
// Port-level assertions for the joint friction block and their bind.
`default_nettype none
module jflt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_status,
  input wire logic [31:0] out_viscous_torque,
  input wire logic [31:0] out_friction_torque,
  input wire logic [31:0] out_limit_torque,
  input wire logic [31:0] out_total_torque
);
  // Hold a stalled result's valid and total torque
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_torque))
    else $error("stalled result changed");

  // Input side never stalls while the output slot is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Input stalls exactly when a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

  // Bad row gives zero torques
  a_bad_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_viscous_torque == 32'd0) &&
      (out_friction_torque == 32'd0) && (out_limit_torque == 32'd0) &&
      (out_total_torque == 32'd0))
    else $error("nonzero torque on bad row");
endmodule

bind joint_friction_limit_torque jflt_checker u_jflt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_viscous_torque  (out_viscous_torque),
  .out_friction_torque (out_friction_torque),
  .out_limit_torque    (out_limit_torque),
  .out_total_torque    (out_total_torque)
);
`default_nettype wire
